// ===== src/ffhs_pkg.sv =====
// Shared types, constants and the CRC-8 step function for the frame header sync.
`default_nettype none
package ffhs_pkg;

  // Header buffer geometry.
  localparam int STORE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int LEN_W       = 5;

  // Sync pattern bytes.
  localparam logic [7:0] SYNC1_BYTE  = 8'hFF;
  localparam logic [7:0] SYNC2_FIXED = 8'hF8;
  localparam logic [7:0] SYNC2_VAR   = 8'hF9;

  // CRC-8 generator polynomial x^8 + x^2 + x + 1, MSB first.
  localparam logic [7:0] CRC8_POLY = 8'h07;

  // Command from the hunter to the readout sequencer.
  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] last_idx;
  } rd_cmd_t;

  // Status from the readout sequencer back to the hunter.
  typedef struct packed {
    logic busy;
  } rd_stat_t;

  // One byte of CRC-8 update, no reflection.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC8_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/ffhs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ffhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; the read data register holds until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/ffhs_readout.sv =====
// Readout sequencer: reads a found header from the buffer RAM and drives the result channel.
`default_nettype none
module ffhs_readout
  import ffhs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rd_cmd_t          cmd,
  output rd_stat_t              stat,
  output logic                  ram_rd_en,
  output logic [IDX_W-1:0]      ram_rd_addr,
  input  wire logic [7:0]       ram_rd_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_header_byte,
  output logic [IDX_W-1:0]      out_byte_index,
  output logic                  out_last_byte
);

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r;
  logic             pend_last_r;
  logic             oval_r, oval_nxt;
  logic [7:0]       obyte_r;
  logic [IDX_W-1:0] oidx_r;
  logic             olast_r;
  logic             xfer;
  logic             issue;

  // A pending RAM word moves to the output register when that register frees up.
  assign xfer  = pend_r && (!oval_r || out_ready);
  // A new read is issued only when the RAM data register is free or being emptied.
  assign issue = busy_r && (!pend_r || xfer);

  assign ram_rd_en   = issue;
  assign ram_rd_addr = addr_r;
  assign stat.busy   = busy_r;

  // Next-state logic for the sequencer.
  always_comb begin
    busy_nxt = busy_r;
    addr_nxt = addr_r;
    last_nxt = last_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      addr_nxt = '0;
      last_nxt = cmd.last_idx;
    end else if (issue) begin
      addr_nxt = addr_r + 1'b1;
      if (addr_r == last_r) begin
        busy_nxt = 1'b0;
      end
    end
    if (issue) begin
      pend_nxt = 1'b1;
    end else if (xfer) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
    if (xfer) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      oval_r <= 1'b0;
      addr_r <= '0;
      last_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      oval_r <= oval_nxt;
      addr_r <= addr_nxt;
      last_r <= last_nxt;
    end
  end

  // Payload registers follow the read data through the output stage.
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx_r  <= addr_r;
      pend_last_r <= (addr_r == last_r);
    end
    if (xfer) begin
      obyte_r <= ram_rd_data;
      oidx_r  <= pend_idx_r;
      olast_r <= pend_last_r;
    end
  end

  assign out_valid       = oval_r;
  assign out_header_byte = obyte_r;
  assign out_byte_index  = oidx_r;
  assign out_last_byte   = olast_r;

endmodule
`default_nettype wire

// ===== src/flac_frame_header_sync.sv =====
// Top level: hunts for a CRC-8 checked frame header and emits its bytes.
//
// Input channel: one stream byte per beat on in_data_byte (in_valid/in_ready).
// Result channel: one header byte per beat on out_header_byte with its position
// out_byte_index and out_last_byte set on the closing CRC byte.
// With the readout sequencer idle, one input byte is taken every cycle while
// hunting and collecting; candidate bytes are written to a 16-entry buffer RAM
// and the CRC-8 (polynomial 0x07, initial zero) is updated in the same cycle.
// When the CRC over the candidate reaches zero, the input side stalls while the
// readout sequencer reads the buffer RAM one entry per cycle unless the receiver
// stalls. Each entry is read into the RAM read data register and then moved to
// the output register, and in_ready stays low until the read of the last entry
// is issued. The readout rate is set by the single RAM read port. A receiver
// stall holds the output register and the RAM read data register, and pauses
// the sequencer without losing any beat.
// Candidates that reach MAX_HEADER bytes with a nonzero CRC are dropped silently.
// Reset (rst_n low, synchronous) returns the hunter to searching for 0xFF and
// empties the result channel; the buffer contents are not cleared.
`default_nettype none
module flac_frame_header_sync
  import ffhs_pkg::*;
#(
  parameter int MAX_HEADER = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_data_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_header_byte,
  output logic [IDX_W-1:0]      out_byte_index,
  output logic                  out_last_byte
);

  localparam int LIMIT = (MAX_HEADER > STORE_DEPTH) ? STORE_DEPTH :
                         ((MAX_HEADER < 3) ? 3 : MAX_HEADER);
  localparam logic [LEN_W-1:0] LIMIT_LEN = LEN_W'(LIMIT);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_SYNC2,
    ST_COLLECT
  } state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             accept;
  logic [7:0]       crc_app;
  logic [LEN_W-1:0] len_inc;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             append;
  rd_cmd_t          rd_cmd;
  rd_stat_t         rd_stat;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [7:0]       ram_rd_data;

  assign in_ready = !rd_stat.busy;
  assign accept   = in_valid && in_ready;
  assign crc_app  = crc8_step(crc_r, in_data_byte);
  assign len_inc  = len_r + 1'b1;
  assign wr_addr  = (state_r == ST_HUNT) ? '0 : len_r[IDX_W-1:0];

  // Hunter: sync detection, CRC tracking and buffer writes.
  always_comb begin
    state_nxt       = state_r;
    crc_nxt         = crc_r;
    len_nxt         = len_r;
    wr_en           = 1'b0;
    append          = 1'b0;
    rd_cmd.start    = 1'b0;
    rd_cmd.last_idx = len_r[IDX_W-1:0];
    unique case (state_r)
      ST_HUNT: begin
        if (accept && in_data_byte == SYNC1_BYTE) begin
          wr_en     = 1'b1;
          crc_nxt   = crc8_step(8'h00, SYNC1_BYTE);
          len_nxt   = LEN_W'(1);
          state_nxt = ST_SYNC2;
        end
      end
      ST_SYNC2: begin
        if (accept) begin
          if (in_data_byte == SYNC2_FIXED || in_data_byte == SYNC2_VAR) begin
            append = 1'b1;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_COLLECT: begin
        if (accept) begin
          append = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
    // Append the beat, then close, drop or keep collecting.
    if (append) begin
      wr_en = 1'b1;
      if (crc_app == 8'h00) begin
        rd_cmd.start = 1'b1;
        state_nxt    = ST_HUNT;
        len_nxt      = '0;
        crc_nxt      = 8'h00;
      end else if (len_inc >= LIMIT_LEN) begin
        state_nxt = ST_HUNT;
        len_nxt   = '0;
        crc_nxt   = 8'h00;
      end else begin
        state_nxt = ST_COLLECT;
        len_nxt   = len_inc;
        crc_nxt   = crc_app;
      end
    end
  end

  // Hunter state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      crc_r   <= 8'h00;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      crc_r   <= crc_nxt;
      len_r   <= len_nxt;
    end
  end

  // Header buffer.
  ffhs_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Readout sequencer and output register.
  ffhs_readout u_readout (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (rd_cmd),
    .stat            (rd_stat),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_header_byte (out_header_byte),
    .out_byte_index  (out_byte_index),
    .out_last_byte   (out_last_byte)
  );

  // A found header blocks the input side on the next cycle.
  a_start_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    rd_cmd.start |=> !in_ready)
    else $error("input not stalled after a header was found");

  // The candidate length never reaches the size limit between beats.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r < LIMIT_LEN)
    else $error("candidate length at or above limit");

  // A candidate past the first sync byte always holds at least that byte.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_HUNT) |-> (len_r != '0))
    else $error("empty candidate outside hunting");

endmodule
`default_nettype wire

// ===== sim/flac_frame_header_sync_tb.sv =====
// Self-checking testbench for the frame header sync block: directed table, then random streams.
module flac_frame_header_sync_tb;
  import ffhs_pkg::*;

  localparam int MAX_HDR       = 16;
  localparam int RANDOM_ITEMS  = 370;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 60;
  localparam int REPORT_MAX    = 10;

  typedef enum logic [1:0] {PH_HUNT, PH_SYNC2, PH_COLLECT} hunt_phase_t;

  // Quiet rows are typed as causing no beat at all; checked rows go through the
  // predictor; a closing row sends whatever byte brings the running CRC to zero.
  typedef enum logic [1:0] {ROW_QUIET, ROW_CHECKED, ROW_CLOSE} row_kind_t;

  typedef struct {
    logic [7:0] data;
    row_kind_t  kind;
  } stim_row_t;

  typedef struct {
    logic [7:0]       hbyte;
    logic [IDX_W-1:0] idx;
    logic             last;
  } hdr_beat_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_data_byte;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       out_header_byte;
  logic [IDX_W-1:0] out_byte_index;
  logic             out_last_byte;

  // Predictor state for the header hunter.
  hunt_phase_t phase_q = PH_HUNT;
  logic [7:0]  crc_q = 8'h00;
  int unsigned hdr_len = 0;
  logic [7:0]  hdr_buf [STORE_DEPTH];

  hdr_beat_t   header_beats_q[$];
  int unsigned beats_seen = 0;
  int unsigned failures = 0;
  int unsigned cycles = 0;

  flac_frame_header_sync #(.MAX_HEADER(MAX_HDR)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_header_byte (out_header_byte),
    .out_byte_index  (out_byte_index),
    .out_last_byte   (out_last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d beats still expected",
               cycles, header_beats_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("ERROR: %s", msg);
  endfunction

  // CRC-8, polynomial 0x07, MSB first, no reflection.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    repeat (8) r = r[7] ? ((r << 1) ^ CRC8_POLY) : (r << 1);
    return r;
  endfunction

  function automatic void buffer_byte(input logic [7:0] b);
    hdr_buf[hdr_len % STORE_DEPTH] = b;
    hdr_len++;
    crc_q = crc8_update(crc_q, b);
  endfunction

  // Advances the predicted hunter by one accepted byte and queues the header
  // beats it releases. Returns 1 when the byte was simply skipped while hunting.
  function automatic bit track_byte(input logic [7:0] b, input bit quiet);
    hdr_beat_t beat;
    if (phase_q == PH_SYNC2 && b != SYNC2_FIXED && b != SYNC2_VAR) begin
      phase_q = PH_HUNT;
      return 1'b0;
    end
    if (phase_q != PH_SYNC2 && phase_q != PH_COLLECT) begin
      if (b != SYNC1_BYTE) return 1'b1;
      hdr_len = 0;
      crc_q   = 8'h00;
      buffer_byte(b);
      phase_q = PH_SYNC2;
      return 1'b0;
    end
    buffer_byte(b);
    phase_q = PH_COLLECT;
    if (crc_q == 8'h00) begin
      // Header closed: every buffered byte goes out, the last one marked.
      if (!quiet) begin
        for (int k = 0; k < hdr_len; k++) begin
          beat.hbyte = hdr_buf[k % STORE_DEPTH];
          beat.idx   = IDX_W'(k);
          beat.last  = (k == hdr_len - 1);
          header_beats_q = {header_beats_q, beat};
        end
      end
      phase_q = PH_HUNT;
      hdr_len = 0;
    end else if (hdr_len >= MAX_HDR) begin
      // Too long without a zero CRC: the candidate is thrown away.
      phase_q = PH_HUNT;
      hdr_len = 0;
      crc_q   = 8'h00;
    end
    return 1'b0;
  endfunction

  // Offers one byte, holds it until accepted, then maybe idles for a while.
  task automatic send_byte(input logic [7:0] b, input bit quiet, input bit no_gap,
                           output bit skipped);
    int unsigned gap;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    skipped = track_byte(b, quiet);
    if (!no_gap && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic play_rows(input stim_row_t rows[$], input bit no_gap,
                           inout int unsigned counted);
    logic [7:0] b;
    bit         skipped;
    foreach (rows[i]) begin
      b = rows[i].data;
      if (rows[i].kind == ROW_CLOSE && phase_q == PH_COLLECT) b = crc_q;
      send_byte(b, rows[i].kind == ROW_QUIET, no_gap, skipped);
      if (!skipped) counted++;
    end
  endtask

  // Result side: compare every accepted beat with the oldest expected one.
  always @(posedge clk) begin : check_beats
    hdr_beat_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      beats_seen++;
      if (header_beats_q.size() == 0) begin
        note_failure($sformatf("unexpected beat byte=%02h idx=%0d last=%0b",
                               out_header_byte, out_byte_index, out_last_byte));
      end else begin
        want = header_beats_q.pop_front();
        if (out_header_byte !== want.hbyte || out_byte_index !== want.idx ||
            out_last_byte !== want.last) begin
          note_failure($sformatf(
            "beat mismatch: expected byte=%02h idx=%0d last=%0b, got byte=%02h idx=%0d last=%0b",
            want.hbyte, want.idx, want.last,
            out_header_byte, out_byte_index, out_last_byte));
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off once headers are flowing.
  initial begin : drain
    int unsigned run;
    int unsigned pick;
    bit          held;
    held = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && beats_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          out_ready <= 1'b1;
          run = $urandom_range(1, 20);
        end else if (pick < 9) begin
          out_ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          run = $urandom_range(10, 40);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  // Sender: reset, directed table, random byte streams, then drain and verdict.
  initial begin : stimulus
    stim_row_t   directed_rows[$];
    stim_row_t   seq[$];
    stim_row_t   row;
    int unsigned counted;
    int unsigned pick;
    int unsigned len;
    bit          burst;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    directed_rows = '{
      // Plain byte right after reset is skipped.
      '{8'h00, ROW_QUIET},
      // A second 0xFF is a bad second sync byte and is dropped, not a new start.
      '{8'hFF, ROW_QUIET}, '{8'hFF, ROW_QUIET},
      // With the candidate gone, 0xF8 is just hunted over.
      '{8'hF8, ROW_QUIET},
      // Ordinary bad second sync byte.
      '{8'hFF, ROW_QUIET}, '{8'h07, ROW_QUIET},
      // Full-length candidate with a nonzero CRC: dropped at the size limit.
      '{8'hFF, ROW_CHECKED}, '{8'hF8, ROW_CHECKED},
      '{8'h00, ROW_CHECKED}, '{8'hFF, ROW_CHECKED}, '{8'h80, ROW_CHECKED},
      '{8'h01, ROW_CHECKED}, '{8'h7F, ROW_CHECKED}, '{8'hFE, ROW_CHECKED},
      '{8'hAA, ROW_CHECKED}, '{8'h55, ROW_CHECKED}, '{8'h0F, ROW_CHECKED},
      '{8'hF0, ROW_CHECKED}, '{8'h12, ROW_CHECKED}, '{8'h34, ROW_CHECKED},
      '{8'hC3, ROW_CHECKED}, '{8'h3C, ROW_CHECKED},
      // Shortest header that can close: sync pair plus the CRC byte.
      '{8'hFF, ROW_CHECKED}, '{8'hF9, ROW_CHECKED}, '{8'h00, ROW_CLOSE}
    };
    counted = 0;
    play_rows(directed_rows, 1'b0, counted);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      seq.delete();
      burst = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 88) begin
        row = '{SYNC1_BYTE, ROW_CHECKED};
        seq = {seq, row};
        if (pick < 78) begin
          row.data = $urandom_range(0, 1) ? SYNC2_VAR : SYNC2_FIXED;
        end else begin
          // Broken pair: random second byte, 0xFF a third of the time.
          row.data = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
        end
        seq = {seq, row};
        if (pick < 65) begin
          // Well-formed header, now and then at full length.
          len = ($urandom_range(0, 4) == 0) ? MAX_HDR - 3 : $urandom_range(0, MAX_HDR - 4);
        end else if (pick < 78) begin
          // Oversized candidate that will most likely hit the size limit.
          len = MAX_HDR - 2;
        end else begin
          len = $urandom_range(0, 3);
        end
        repeat (len) begin
          row.data = 8'($urandom_range(0, 255));
          seq = {seq, row};
        end
        if (pick < 65) begin
          row.kind = ROW_CLOSE;
          seq = {seq, row};
        end
      end else begin
        // Noise between headers.
        repeat ($urandom_range(1, 4)) begin
          row = '{8'($urandom_range(0, 255)), ROW_CHECKED};
          seq = {seq, row};
        end
      end
      play_rows(seq, burst, counted);
    end

    in_valid <= 1'b0;
    while (header_beats_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
